// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers used by the checker file tcq_checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// generic form with explicit clock and active-low reset
`define TCQ_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// default clock and reset of the block
`define TCQ_ASSERT_CLK(name, prop) \
  `TCQ_ASSERT(name, clk_i, rst_ni, prop)

`endif

// ----- rtl/tcq_pkg.sv -----
// ----------------------------------------------------------------------------
// tcq_pkg
// types, constants and ring helpers of the two-class command ring queue
// ----------------------------------------------------------------------------
package tcq_pkg;

  localparam int DEPTH   = 16;
  localparam int BUF_LEN = 1024;
  localparam int DATA_W  = 32;

  localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LEN_W   = 12;
  localparam int PAY_W   = 32;
  localparam int SLOT_W  = 4;
  localparam int STORE_W = (DATA_W < PAY_W) ? DATA_W : PAY_W;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef enum logic [1:0] {
    CMD_ADD      = 2'd0,
    CMD_GET      = 2'd1,
    CMD_FAST_GET = 2'd2,
    CMD_DELETE   = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e             cmd;
    logic             priority_req;
    logic [LEN_W-1:0] length;
    logic [PAY_W-1:0] payload;
  } req_t;

  typedef struct packed {
    logic              ok;
    logic [SLOT_W-1:0] slot;
    logic              out_priority;
    logic [LEN_W-1:0]  out_length;
    logic [PAY_W-1:0]  out_payload;
  } rsp_t;

  typedef struct packed {
    logic add_en;
    logic del_en;
    logic setup_en;
    logic scan_en;
    logic emit_en;
  } ctrl_t;

  typedef struct packed {
    logic scan_end;
    logic scan_hit;
  } stat_t;

  function automatic ptr_t ring_next(ptr_t p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : ptr_t'(p + 1'b1);
  endfunction

  function automatic ptr_t ring_prev(ptr_t p);
    return (p == '0) ? PTR_W'(DEPTH - 1) : ptr_t'(p - 1'b1);
  endfunction

  function automatic ptr_t ring_add(ptr_t a, ptr_t b);
    logic [PTR_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (PTR_W+1)'(DEPTH)) begin
      s = s - (PTR_W+1)'(DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

  // ring distance from base to p
  function automatic ptr_t ring_dist(ptr_t p, ptr_t base);
    logic [PTR_W:0] s;
    if (p >= base) begin
      s = {1'b0, p} - {1'b0, base};
    end else begin
      s = {1'b0, p} + (PTR_W+1)'(DEPTH) - {1'b0, base};
    end
    return s[PTR_W-1:0];
  endfunction

endpackage

// ----- rtl/tcq_ctrl.sv -----
// ----------------------------------------------------------------------------
// tcq_ctrl
// command sequencer: add and delete finish in the accepting cycle, slot scan for the gets
// ----------------------------------------------------------------------------
module tcq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  tcq_pkg::cmd_e  cmd_i,
  input  tcq_pkg::stat_t stat_i,
  output tcq_pkg::ctrl_t ctrl_o,
  output logic           busy
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          unique case (cmd_i)
            tcq_pkg::CMD_ADD:    ctrl_o.add_en = 1'b1;
            tcq_pkg::CMD_DELETE: ctrl_o.del_en = 1'b1;
            default: begin
              ctrl_o.setup_en = 1'b1;
              state_d         = S_SCAN;
            end
          endcase
        end
      end
      S_SCAN: begin
        ctrl_o.scan_en = 1'b1;
        if (stat_i.scan_end) begin
          state_d = S_IDLE;
        end else if (stat_i.scan_hit) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        ctrl_o.emit_en = 1'b1;
        state_d        = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

// ----- rtl/tcq_datapath.sv -----
// ----------------------------------------------------------------------------
// tcq_datapath
// ring pointers, entry storage, scan counter and result register
// ----------------------------------------------------------------------------
module tcq_datapath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tcq_pkg::req_t  req_i,
  input  tcq_pkg::ctrl_t ctrl_i,
  output tcq_pkg::stat_t stat_o,
  output tcq_pkg::rsp_t  rsp_o,
  output logic           rsp_valid_o
);

  tcq_pkg::ptr_t wp_q, wp_d, rp_q, rp_d, fp_q, fp_d;
  tcq_pkg::ptr_t d_q, d_d, region_q, region_d, taken_q, taken_d;
  logic          fast_q, fast_d;

  logic                       pri_q [tcq_pkg::DEPTH];
  logic [tcq_pkg::LEN_W-1:0]   len_mem [tcq_pkg::DEPTH];
  logic [tcq_pkg::STORE_W-1:0] pay_mem [tcq_pkg::DEPTH];

  logic [tcq_pkg::LEN_W-1:0]   rd_len_q;
  logic [tcq_pkg::STORE_W-1:0] rd_pay_q;
  tcq_pkg::ptr_t               hit_slot_q;
  logic                        hit_pri_q;

  tcq_pkg::rsp_t rsp_q, rsp_d;
  logic          rsp_valid_q, rsp_valid_d;

  tcq_pkg::ptr_t region, fdist, taken, scan_idx, del_idx;
  logic          scan_pri, scan_end, scan_hit, add_ok, del_ok;

  assign region   = tcq_pkg::ring_dist(wp_q, rp_q);
  assign fdist    = tcq_pkg::ring_dist(fp_q, rp_q);
  assign taken    = (fdist <= region) ? fdist : '0;
  assign scan_idx = tcq_pkg::ring_add(rp_q, d_q);
  assign scan_pri = pri_q[scan_idx];
  assign scan_end = (d_q == region_q);
  assign scan_hit = !scan_end && (fast_q ? scan_pri : (!scan_pri || (d_q >= taken_q)));
  assign add_ok   = (req_i.length <= tcq_pkg::LEN_W'(tcq_pkg::BUF_LEN));
  assign del_ok   = (rp_q != wp_q);
  assign del_idx  = tcq_pkg::ring_prev(wp_q);

  always_comb begin
    wp_d        = wp_q;
    rp_d        = rp_q;
    fp_d        = fp_q;
    d_d         = d_q;
    region_d    = region_q;
    taken_d     = taken_q;
    fast_d      = fast_q;
    rsp_d       = rsp_q;
    rsp_valid_d = 1'b0;

    if (ctrl_i.add_en) begin
      rsp_valid_d = 1'b1;
      rsp_d       = '0;
      if (add_ok) begin
        wp_d       = tcq_pkg::ring_next(wp_q);
        rsp_d.ok   = 1'b1;
        rsp_d.slot = tcq_pkg::SLOT_W'(wp_q);
      end
    end

    if (ctrl_i.del_en) begin
      rsp_valid_d = 1'b1;
      rsp_d       = '0;
      if (del_ok) begin
        wp_d = del_idx;
        if (fp_q == wp_q) begin
          fp_d = del_idx;
        end
        rsp_d.ok   = 1'b1;
        rsp_d.slot = tcq_pkg::SLOT_W'(del_idx);
      end
    end

    if (ctrl_i.setup_en) begin
      fast_d   = (req_i.cmd == tcq_pkg::CMD_FAST_GET);
      region_d = region;
      taken_d  = taken;
      d_d      = (req_i.cmd == tcq_pkg::CMD_FAST_GET) ? taken : '0;
    end

    if (ctrl_i.scan_en) begin
      if (scan_end) begin
        rsp_valid_d = 1'b1;
        rsp_d       = '0;
        if (fast_q) begin
          fp_d = wp_q;
        end else begin
          rp_d = wp_q;
        end
      end else if (scan_hit) begin
        if (fast_q || scan_pri) begin
          fp_d = tcq_pkg::ring_next(scan_idx);
        end
        if (!fast_q) begin
          rp_d = tcq_pkg::ring_next(scan_idx);
        end
      end else begin
        d_d = tcq_pkg::ptr_t'(d_q + 1'b1);
      end
    end

    if (ctrl_i.emit_en) begin
      rsp_valid_d        = 1'b1;
      rsp_d.ok           = 1'b1;
      rsp_d.slot         = tcq_pkg::SLOT_W'(hit_slot_q);
      rsp_d.out_priority = hit_pri_q;
      rsp_d.out_length   = rd_len_q;
      rsp_d.out_payload  = tcq_pkg::PAY_W'(rd_pay_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      rp_q        <= '0;
      fp_q        <= '0;
      d_q         <= '0;
      region_q    <= '0;
      taken_q     <= '0;
      fast_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      fp_q        <= fp_d;
      d_q         <= d_d;
      region_q    <= region_d;
      taken_q     <= taken_d;
      fast_q      <= fast_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // entry storage and registered read
  always_ff @(posedge clk_i) begin
    if (ctrl_i.add_en && add_ok) begin
      pri_q[wp_q]   <= req_i.priority_req;
      len_mem[wp_q] <= req_i.length;
      pay_mem[wp_q] <= req_i.payload[tcq_pkg::STORE_W-1:0];
    end
    if (ctrl_i.scan_en && scan_hit) begin
      rd_len_q   <= len_mem[scan_idx];
      rd_pay_q   <= pay_mem[scan_idx];
      hit_slot_q <= scan_idx;
      hit_pri_q  <= scan_pri;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign stat_o.scan_end = scan_end;
  assign stat_o.scan_hit = scan_hit;
  assign rsp_o           = rsp_q;
  assign rsp_valid_o     = rsp_valid_q;

endmodule

// ----- rtl/two_class_command_ring_queue_core.sv -----
// ----------------------------------------------------------------------------
// two_class_command_ring_queue_core
// ring queue of command entries with a normal and a high-priority reader
// ----------------------------------------------------------------------------
// A command is taken at a clock edge with start high and busy low; its result
// shows on rsp_o for exactly one cycle with rsp_valid_o high, starting in the
// cycle after the command finishes, and must be captured then since there is
// no stall. Add and delete finish in the accepting cycle, so a new command can
// follow every cycle. A get first sets up its scan, then scans the ring one
// slot per cycle from its start point (at most DEPTH-1 slots), then, when a
// slot is found, passes an emit state that returns the entry read from the
// entry storage, with busy high from the end of the setup until the result
// shows.
module two_class_command_ring_queue_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  tcq_pkg::req_t req_i,
  output tcq_pkg::rsp_t rsp_o,
  output logic          rsp_valid_o
);

  tcq_pkg::ctrl_t ctrl;
  tcq_pkg::stat_t stat;

  tcq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .cmd_i  (req_i.cmd),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .busy   (busy)
  );

  tcq_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .rsp_o       (rsp_o),
    .rsp_valid_o (rsp_valid_o)
  );

endmodule

// ----- rtl/tcq_checker.sv -----
// ----------------------------------------------------------------------------
// tcq_checker
// port-level checks of the ring queue, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcq_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input tcq_pkg::req_t req_i,
  input tcq_pkg::rsp_t rsp_o,
  input logic          rsp_valid_o
);

  logic acc;

  assign acc = start && !busy;

  `TCQ_ASSERT_CLK(a_fail_clean, rsp_valid_o && !rsp_o.ok |-> rsp_o.slot == '0 && !rsp_o.out_priority && rsp_o.out_length == '0 && rsp_o.out_payload == '0)
  `TCQ_ASSERT_CLK(a_quick_result, acc && (req_i.cmd == tcq_pkg::CMD_ADD || req_i.cmd == tcq_pkg::CMD_DELETE) |=> rsp_valid_o)
  `TCQ_ASSERT_CLK(a_result_idle, rsp_valid_o |-> !busy)
  `TCQ_ASSERT_CLK(a_get_busy, acc && (req_i.cmd == tcq_pkg::CMD_GET || req_i.cmd == tcq_pkg::CMD_FAST_GET) |=> busy && !rsp_valid_o)
  `TCQ_ASSERT_CLK(a_long_reject, acc && req_i.cmd == tcq_pkg::CMD_ADD && req_i.length > tcq_pkg::LEN_W'(tcq_pkg::BUF_LEN) |=> !rsp_o.ok)

endmodule

bind two_class_command_ring_queue_core tcq_checker u_tcq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .req_i       (req_i),
  .rsp_o       (rsp_o),
  .rsp_valid_o (rsp_valid_o)
);

// ----- tb/two_class_command_ring_queue_core_test.sv -----
// ----------------------------------------------------------------------------
// two_class_command_ring_queue_core_test
// self-checking bench for the two-class command ring queue: a queue-fed driver
// sends add, get, fast get and delete commands with random gaps, and a monitor
// keeps its own copy of the ring and pointers, predicts every result and
// compares each result transfer field by field against the oldest prediction
// ----------------------------------------------------------------------------
module two_class_command_ring_queue_core_test;
  import tcq_pkg::*;

  localparam int ITEMS       = 850;
  localparam int WATCH_LIMIT = 2000;
  localparam int SETTLE      = 2 * DEPTH + 4;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  cmd_start = 1'b0;
  req_t  cmd_bus = '0;
  logic  busy;
  rsp_t  rsp_o;
  logic  rsp_valid_o;

  two_class_command_ring_queue_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (cmd_start),
    .busy       (busy),
    .req_i      (cmd_bus),
    .rsp_o      (rsp_o),
    .rsp_valid_o(rsp_valid_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // commands waiting to be sent, with a flag to let the queue drain first
  req_t cmd_q [$];
  bit   drain_first_q [$];
  rsp_t due_rsp [$];

  // mirror of the ring
  logic             prio_mem [DEPTH];
  logic [LEN_W-1:0] len_mem  [DEPTH];
  logic [PAY_W-1:0] pay_mem  [DEPTH];
  int wr_ptr = 0;
  int rd_ptr = 0;
  int fast_ptr = 0;

  int fail_count = 0;
  int sent_count = 0;
  int idle_cycles = 0;
  int n_add = 0, n_get = 0, n_fast = 0, n_del = 0, n_served = 0, n_refused = 0;

  int  gap_left = 0;
  int  steady_left = 0;
  bit  drain_wait = 1'b0;
  req_t held_cmd;

  function automatic int ring_gap(int p);
    return (p + DEPTH - rd_ptr) % DEPTH;
  endfunction

  function automatic rsp_t queue_outcome(req_t r);
    rsp_t o;
    int   region, fgap, from, d, idx;
    bit   found;
    o = '0;
    found = 1'b0;
    idx = 0;
    region = ring_gap(wr_ptr);
    fgap = ring_gap(fast_ptr);
    // high entries below this distance were already taken by the fast reader
    from = (fgap <= region) ? fgap : 0;
    case (r.cmd)
      CMD_ADD: begin
        if (r.length <= BUF_LEN) begin
          prio_mem[wr_ptr] = r.priority_req;
          len_mem[wr_ptr] = r.length;
          pay_mem[wr_ptr] = r.payload;
          o.ok = 1'b1;
          o.slot = SLOT_W'(wr_ptr);
          wr_ptr = (wr_ptr + 1) % DEPTH;
        end
      end
      CMD_GET: begin
        for (d = 0; d < region && !found; d++) begin
          idx = (rd_ptr + d) % DEPTH;
          if (!prio_mem[idx] || d >= from) found = 1'b1;
        end
        if (found) begin
          if (prio_mem[idx]) fast_ptr = (idx + 1) % DEPTH;
          rd_ptr = (idx + 1) % DEPTH;
        end else begin
          rd_ptr = wr_ptr;
        end
      end
      CMD_FAST_GET: begin
        for (d = from; d < region && !found; d++) begin
          idx = (rd_ptr + d) % DEPTH;
          if (prio_mem[idx]) found = 1'b1;
        end
        fast_ptr = found ? (idx + 1) % DEPTH : wr_ptr;
      end
      default: begin
        if (rd_ptr != wr_ptr) begin
          idx = (wr_ptr + DEPTH - 1) % DEPTH;
          if (fast_ptr == wr_ptr) fast_ptr = idx;
          wr_ptr = idx;
          o.ok = 1'b1;
          o.slot = SLOT_W'(idx);
        end
      end
    endcase
    if (found) begin
      o.ok = 1'b1;
      o.slot = SLOT_W'(idx);
      o.out_priority = prio_mem[idx];
      o.out_length = len_mem[idx];
      o.out_payload = pay_mem[idx];
    end
    return o;
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady_left > 0) begin
      steady_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      steady_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [LEN_W-1:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return LEN_W'($urandom_range(BUF_LEN + 1, (1 << LEN_W) - 1));
    if (r < 11) return LEN_W'(BUF_LEN);
    if (r < 14) return '0;
    return LEN_W'($urandom_range(0, BUF_LEN));
  endfunction

  function automatic req_t rand_cmd(cmd_e c);
    req_t r;
    r.cmd = c;
    r.priority_req = 1'($urandom_range(0, 1));
    r.length = pick_length();
    r.payload = $urandom;
    return r;
  endfunction

  function automatic req_t make_cmd(cmd_e c, logic pri, int len, logic [PAY_W-1:0] pay);
    req_t r;
    r.cmd = c;
    r.priority_req = pri;
    r.length = LEN_W'(len);
    r.payload = pay;
    return r;
  endfunction

  task automatic queue_cmd(req_t r, bit drain_first);
    cmd_q.push_back(r);
    drain_first_q.push_back(drain_first);
  endtask

  // driver
  always @(posedge clk_i) begin : drive_proc
    logic next_start;
    if (rst_ni) begin
      next_start = cmd_start;
      if (cmd_start && !busy) begin
        sent_count++;
        next_start = 1'b0;
      end
      if (!next_start) begin
        if (drain_wait) begin
          if (due_rsp.size() == 0 && !rsp_valid_o) begin
            drain_wait = 1'b0;
            cmd_bus <= held_cmd;
            next_start = 1'b1;
            gap_left = pick_gap();
          end
        end else if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_q.size() > 0) begin
          held_cmd = cmd_q.pop_front();
          if (drain_first_q.pop_front()) begin
            drain_wait = 1'b1;
          end else begin
            cmd_bus <= held_cmd;
            next_start = 1'b1;
            gap_left = pick_gap();
          end
        end
      end
      cmd_start <= next_start;
    end
  end

  // monitor, predictor and watchdog
  always @(posedge clk_i) begin : watch_proc
    rsp_t exp_rsp;
    if (rst_ni) begin
      if (rsp_valid_o) begin
        if (due_rsp.size() == 0) begin
          $error("result transfer with no command outstanding");
          fail_count++;
        end else begin
          exp_rsp = due_rsp.pop_front();
          if (rsp_o.ok !== exp_rsp.ok) begin
            $error("ok: expected %0d, got %0d", exp_rsp.ok, rsp_o.ok);
            fail_count++;
          end
          if (rsp_o.slot !== exp_rsp.slot) begin
            $error("slot: expected %0d, got %0d", exp_rsp.slot, rsp_o.slot);
            fail_count++;
          end
          if (rsp_o.out_priority !== exp_rsp.out_priority) begin
            $error("out_priority: expected %0d, got %0d",
                   exp_rsp.out_priority, rsp_o.out_priority);
            fail_count++;
          end
          if (rsp_o.out_length !== exp_rsp.out_length) begin
            $error("out_length: expected %0d, got %0d",
                   exp_rsp.out_length, rsp_o.out_length);
            fail_count++;
          end
          if (rsp_o.out_payload !== exp_rsp.out_payload) begin
            $error("out_payload: expected %h, got %h",
                   exp_rsp.out_payload, rsp_o.out_payload);
            fail_count++;
          end
        end
      end
      if (cmd_start && !busy) begin
        exp_rsp = queue_outcome(cmd_bus);
        due_rsp.push_back(exp_rsp);
        case (cmd_bus.cmd)
          CMD_ADD:      n_add++;
          CMD_GET:      n_get++;
          CMD_FAST_GET: n_fast++;
          default:      n_del++;
        endcase
        if (!exp_rsp.ok) n_refused++;
        else if (cmd_bus.cmd == CMD_GET || cmd_bus.cmd == CMD_FAST_GET) n_served++;
      end
      if (rsp_valid_o || (cmd_start && !busy)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCH_LIMIT) begin
          $display("timeout: no transfer for %0d cycles", WATCH_LIMIT);
          $display("end of test: mismatches");
          $finish;
        end
      end
    end
  end

  initial begin : stim_proc
    int made, kind, n, i, r;
    bit hold;
    cmd_e c;

    // empty queue, length limits, fast/normal interplay, delete cases
    queue_cmd(make_cmd(CMD_DELETE, 1'b1, 4095, '1), 1'b0);
    queue_cmd(make_cmd(CMD_GET, 1'b0, 0, '0), 1'b0);
    queue_cmd(make_cmd(CMD_FAST_GET, 1'b1, 0, '0), 1'b0);
    queue_cmd(make_cmd(CMD_ADD, 1'b0, 0, '0), 1'b0);
    queue_cmd(make_cmd(CMD_ADD, 1'b1, BUF_LEN, '1), 1'b0);
    queue_cmd(make_cmd(CMD_ADD, 1'b0, BUF_LEN + 1, 32'h1234_5678), 1'b0);
    queue_cmd(make_cmd(CMD_ADD, 1'b1, 4095, 32'h8765_4321), 1'b0);
    queue_cmd(make_cmd(CMD_ADD, 1'b1, 1, 32'ha5a5_a5a5), 1'b0);
    queue_cmd(make_cmd(CMD_FAST_GET, 1'b0, 0, '0), 1'b0);
    queue_cmd(make_cmd(CMD_GET, 1'b0, 0, '0), 1'b0);
    queue_cmd(make_cmd(CMD_GET, 1'b0, 0, '0), 1'b0);
    queue_cmd(make_cmd(CMD_FAST_GET, 1'b0, 0, '0), 1'b0);
    queue_cmd(make_cmd(CMD_ADD, 1'b0, 12, 32'h5a5a_5a5a), 1'b1);
    queue_cmd(make_cmd(CMD_ADD, 1'b1, 7, 32'hdead_beef), 1'b0);
    queue_cmd(make_cmd(CMD_FAST_GET, 1'b0, 0, '0), 1'b0);
    queue_cmd(make_cmd(CMD_DELETE, 1'b0, 0, '0), 1'b0);
    queue_cmd(make_cmd(CMD_DELETE, 1'b0, 0, '0), 1'b0);
    queue_cmd(make_cmd(CMD_GET, 1'b0, 0, '0), 1'b0);
    queue_cmd(make_cmd(CMD_DELETE, 1'b0, 0, '0), 1'b0);
    queue_cmd(make_cmd(CMD_ADD, 1'b1, 100, 32'h0f0f_0f0f), 1'b0);
    queue_cmd(make_cmd(CMD_ADD, 1'b0, 200, 32'hf0f0_f0f0), 1'b0);
    queue_cmd(make_cmd(CMD_ADD, 1'b1, 300, 32'h0000_0001), 1'b0);
    queue_cmd(make_cmd(CMD_GET, 1'b0, 0, '0), 1'b0);
    queue_cmd(make_cmd(CMD_GET, 1'b0, 0, '0), 1'b0);
    queue_cmd(make_cmd(CMD_GET, 1'b0, 0, '0), 1'b0);
    made = cmd_q.size();

    // random segments: fill bursts that overrun the ring, read bursts, mixes
    while (made < ITEMS) begin
      kind = $urandom_range(0, 99);
      hold = ($urandom_range(0, 9) == 0);
      n = (kind < 15) ? $urandom_range(12, 20) :
          (kind < 27) ? $urandom_range(6, 18) : 16;
      for (i = 0; i < n; i++) begin
        if (kind < 15) begin
          c = CMD_ADD;
        end else if (kind < 27) begin
          c = $urandom_range(0, 1) ? CMD_GET : CMD_FAST_GET;
        end else begin
          r = $urandom_range(0, 99);
          c = (r < 40) ? CMD_ADD : (r < 65) ? CMD_GET : (r < 85) ? CMD_FAST_GET : CMD_DELETE;
        end
        queue_cmd(rand_cmd(c), hold && i == 0);
        made++;
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (sent_count < made) @(posedge clk_i);
    while (due_rsp.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);

    $display("sent %0d commands: %0d add, %0d get, %0d fast get, %0d delete",
             sent_count, n_add, n_get, n_fast, n_del);
    $display("reads served %0d, refused or empty %0d", n_served, n_refused);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
